// ===== rtl/core/huffman_code_bit_packer_top_macros.svh =====
// assertion macros for the huffman code bit packer
// used by the top level; no other dependencies
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCBP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define HCBP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/hcbp_pkg.sv =====
// shared types and constants for the huffman code bit packer
// no dependencies
package hcbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_WIDTH   = 32;
   localparam int LEN_WIDTH    = 6;
   localparam int SYM_WIDTH    = 8;
   localparam int BYTE_BITS    = 8;
   localparam int TABLE_DEPTH  = 1 << SYM_WIDTH;
   // longest loadable code
   localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_WIDTH) ? MAX_CODE_LEN : CODE_WIDTH;
   // pending bits plus one code
   localparam int ACC_WIDTH    = CODE_WIDTH + BYTE_BITS - 1;
   localparam int CNT_WIDTH    = $clog2(ACC_WIDTH + 1);

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FINISH = 2'd2
   } hcbp_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT,
      ST_FLUSH
   } hcbp_state_type;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [SYM_WIDTH-1:0] symbol;
      logic [31:0]          code_bits;
      logic [5:0]           code_len;
   } hcbp_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } hcbp_rsp_type;

   typedef struct packed {
      logic [LEN_WIDTH-1:0]  len;
      logic [CODE_WIDTH-1:0] code;
   } hcbp_entry_type;

   typedef struct packed {
      logic append;
      logic shift;
      logic clear;
   } hcbp_ctrl_type;

   typedef struct packed {
      logic                 full;
      logic                 append_full;
      logic                 last_byte;
      logic                 empty;
      logic [BYTE_BITS-1:0] low_byte;
   } hcbp_status_type;

endpackage

// ===== rtl/core/huffman_code_bit_packer_top.sv =====
// top level of the huffman code bit packer
// depends on hcbp_pkg, hcbp_table, hcbp_packer and the macros header
//
// usage
//   req channel (valid/ready) carries one command beat: load a table entry,
//   encode a byte, or finish. rsp channel (valid/ready) carries packed bytes,
//   earliest code bit in bit 0, last_of_run set on the final byte of a command.
//   load: written into the table on the accepting edge, no rsp beat, the
//   block is ready again in the next cycle. lengths above the code limit
//   leave the entry untouched.
//   encode: a table read, then the lookup state appends the code, then zero
//   to four rsp beats, one per cycle while rsp is not stalled; ready returns
//   once the last byte is in the output register.
//   finish: one rsp beat with the pending bits zero padded, then cleared.
//   commands are handled one at a time; code 3 is dropped.
//   a stalled rsp holds its beat in the output register and the byte
//   sequencer waits; a new command is still taken while the final byte of
//   the previous one waits to be read.
//   reset clears the pending bits, the sequencer and the output valid flag;
//   the code table is not cleared, encoding an unloaded byte is not allowed.
`include "huffman_code_bit_packer_top_macros.svh"

module huffman_code_bit_packer_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hcbp_pkg::hcbp_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output hcbp_pkg::hcbp_rsp_type rsp_payload
);
   import hcbp_pkg::*;

   hcbp_state_type  state_ff, state_in;
   hcbp_ctrl_type   ctrl;
   hcbp_status_type status;
   hcbp_entry_type  wr_entry, rd_entry;

   logic            req_fire;
   logic            is_load, is_encode, is_finish;
   logic            load_ok;
   logic            out_free;
   logic            emit;
   logic [CODE_WIDTH:0] len_mask;

   logic            rsp_valid_ff, rsp_valid_in;
   hcbp_rsp_type    rsp_payload_ff, rsp_payload_in;

   assign req_fire  = req_valid && req_ready;
   assign is_load   = (req_payload.cmd == CMD_LOAD);
   assign is_encode = (req_payload.cmd == CMD_ENCODE);
   assign is_finish = (req_payload.cmd == CMD_FINISH);
   assign load_ok   = (req_payload.code_len <= LEN_WIDTH'(LEN_LIMIT));

   // mask bits at and above the code length
   assign len_mask       = ((CODE_WIDTH+1)'(1) << req_payload.code_len) - (CODE_WIDTH+1)'(1);
   assign wr_entry.len   = req_payload.code_len;
   assign wr_entry.code  = req_payload.code_bits & len_mask[CODE_WIDTH-1:0];

   // table read lands in the lookup cycle; writes and reads never overlap
   // since a new command waits for the sequencer to return to idle
   hcbp_table u_table (
      .clock   (clock),
      .wr_en   (req_fire && is_load && load_ok),
      .wr_addr (req_payload.symbol),
      .wr_data (wr_entry),
      .rd_en   (req_fire && is_encode),
      .rd_addr (req_payload.symbol),
      .rd_data (rd_entry)
   );

   hcbp_packer u_packer (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .entry  (rd_entry),
      .status (status)
   );

   // output register can take a byte
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = out_free && (state_ff == ST_EMIT || state_ff == ST_FLUSH);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_encode) begin
               state_in = ST_LOOKUP;
            end else if (req_fire && is_finish) begin
               state_in = ST_FLUSH;
            end
         end
         ST_LOOKUP: begin
            state_in = status.append_full ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (emit && status.last_byte) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready   = 1'b0;
      ctrl.append = 1'b0;
      ctrl.shift  = 1'b0;
      ctrl.clear  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready   = 1'b1;
         ST_LOOKUP: ctrl.append = 1'b1;
         ST_EMIT:   ctrl.shift  = emit;
         ST_FLUSH:  ctrl.clear  = emit;
         default:   req_ready   = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_valid_in               = 1'b1;
         rsp_payload_in.out_byte    = status.low_byte;
         rsp_payload_in.last_of_run = (state_ff == ST_FLUSH) || status.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   `HCBP_ASSERT_NOW(a_idle_partial, clock, reset, (state_ff == ST_IDLE), !status.full,
      "full byte left behind in idle")
   `HCBP_ASSERT_NOW(a_emit_has_byte, clock, reset, (state_ff == ST_EMIT), status.full,
      "byte sequencer running without a full byte")
   `HCBP_ASSERT_NEXT(a_flush_clears, clock, reset, (state_ff == ST_FLUSH && emit),
      status.empty && state_ff == ST_IDLE, "pending bits survive a finish")
   `HCBP_ASSERT_NEXT(a_encode_busy, clock, reset, (req_fire && is_encode),
      !req_ready && state_ff == ST_LOOKUP, "encode beat did not start a lookup")

endmodule

// ===== rtl/core/hcbp_table.sv =====
// code table: one entry per byte value, code bits and length
// depends on hcbp_pkg
module hcbp_table (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [hcbp_pkg::SYM_WIDTH-1:0]     wr_addr,
   input  hcbp_pkg::hcbp_entry_type           wr_data,
   input  logic                               rd_en,
   input  logic [hcbp_pkg::SYM_WIDTH-1:0]     rd_addr,
   output hcbp_pkg::hcbp_entry_type           rd_data
);
   import hcbp_pkg::*;

   hcbp_entry_type mem [TABLE_DEPTH];
   hcbp_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hcbp_packer.sv =====
// bit accumulator: appends codes lsb first and drops full bytes
// depends on hcbp_pkg
module hcbp_packer (
   input  logic                       clock,
   input  logic                       reset,
   input  hcbp_pkg::hcbp_ctrl_type    ctrl,
   input  hcbp_pkg::hcbp_entry_type   entry,
   output hcbp_pkg::hcbp_status_type  status
);
   import hcbp_pkg::*;

   logic [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [CNT_WIDTH-1:0] sum;

   // pending count never exceeds seven outside emission
   assign sum = cnt_ff + CNT_WIDTH'(entry.len);

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (ctrl.clear) begin
         acc_in = '0;
         cnt_in = '0;
      end else if (ctrl.append) begin
         acc_in = acc_ff | (ACC_WIDTH'(entry.code) << cnt_ff[2:0]);
         cnt_in = sum;
      end else if (ctrl.shift) begin
         acc_in = acc_ff >> BYTE_BITS;
         cnt_in = cnt_ff - CNT_WIDTH'(BYTE_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign status.full        = (cnt_ff >= CNT_WIDTH'(BYTE_BITS));
   assign status.append_full = (sum >= CNT_WIDTH'(BYTE_BITS));
   assign status.last_byte   = (cnt_ff < CNT_WIDTH'(2 * BYTE_BITS));
   assign status.empty       = (cnt_ff == '0);
   assign status.low_byte    = acc_ff[BYTE_BITS-1:0];

endmodule

// ===== sim/hcbp_stream_checker.sv =====
`timescale 1ns / 100ps
// scoreboard for the huffman code bit packer: mirrors the code table and the
// partial byte, predicts the packed bytes of each request beat, checks rsp beats
// depends on hcbp_pkg only
module hcbp_stream_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  hcbp_pkg::hcbp_req_type req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  hcbp_pkg::hcbp_rsp_type rsp_payload,
   output int                    fail_count,
   output int                    bytes_pending
);
   import hcbp_pkg::*;

   logic [CODE_WIDTH-1:0] code_mirror [TABLE_DEPTH];
   logic [LEN_WIDTH-1:0]  len_mirror  [TABLE_DEPTH];
   logic [6:0]            partial_bits;
   logic [2:0]            partial_count;
   hcbp_rsp_type          expected_bytes [$];

   task automatic note_failure(input string what, input hcbp_rsp_type want);
      if (fail_count < 10) begin
         $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                  $time, what, want.out_byte, want.last_of_run,
                  rsp_payload.out_byte, rsp_payload.last_of_run);
      end
      fail_count++;
   endtask

   task automatic store_code(input hcbp_req_type beat);
      logic [CODE_WIDTH:0] mask_wide;
      // overlong codes leave the entry as it was
      if (beat.code_len <= LEN_LIMIT) begin
         mask_wide = (33'h1 << beat.code_len) - 33'h1;
         code_mirror[beat.symbol] = beat.code_bits & mask_wide[CODE_WIDTH-1:0];
         len_mirror[beat.symbol]  = beat.code_len;
      end
   endtask

   task automatic pack_symbol(input logic [SYM_WIDTH-1:0] sym);
      logic [7:0]   acc;
      int           cnt;
      int           n_bits;
      hcbp_rsp_type run [$];
      hcbp_rsp_type made;
      acc    = {1'b0, partial_bits};
      cnt    = int'(partial_count);
      n_bits = int'(len_mirror[sym]);
      for (int i = 0; i < n_bits; i++) begin
         acc[cnt[2:0]] = code_mirror[sym][i[4:0]];
         cnt++;
         if (cnt == BYTE_BITS) begin
            made.out_byte    = acc;
            made.last_of_run = 1'b0;
            run.push_back(made);
            acc = '0;
            cnt = 0;
         end
      end
      partial_bits  = acc[6:0];
      partial_count = cnt[2:0];
      if (run.size() > 0) begin
         made = run.pop_back();
         made.last_of_run = 1'b1;
         run.push_back(made);
      end
      foreach (run[k]) expected_bytes.push_back(run[k]);
   endtask

   task automatic flush_partial();
      hcbp_rsp_type made;
      made.out_byte    = {1'b0, partial_bits};
      made.last_of_run = 1'b1;
      expected_bytes.push_back(made);
      partial_bits  = '0;
      partial_count = '0;
   endtask

   always @(posedge clock) begin
      hcbp_rsp_type want;
      if (reset) begin
         partial_bits  = '0;
         partial_count = '0;
         expected_bytes.delete();
         fail_count    = 0;
      end else begin
         // predict first, so a beat taken at this edge is queued in order
         if (req_valid && req_ready) begin
            case (req_payload.cmd)
               CMD_LOAD:   store_code(req_payload);
               CMD_ENCODE: pack_symbol(req_payload.symbol);
               CMD_FINISH: flush_partial();
               default:    ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               want = '0;
               note_failure("unexpected rsp beat", want);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_payload.out_byte !== want.out_byte ||
                   rsp_payload.last_of_run !== want.last_of_run) begin
                  note_failure("rsp mismatch", want);
               end
            end
         end
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

// ===== sim/tb_huffman_code_bit_packer_top.sv =====
`timescale 1ns / 100ps
// testbench top for the huffman code bit packer: clock, reset, request and
// response stimulus with random idling, and the final verdict
// depends on hcbp_pkg, hcbp_stream_checker and the packer rtl
module tb_huffman_code_bit_packer_top;
   import hcbp_pkg::*;

   // command code 3 has no meaning and must be dropped by the block
   localparam logic [1:0] CMD_UNUSED      = 2'd3;
   localparam int         RANDOM_ITEMS    = 400;
   localparam int         PHASE_COUNT     = 4;
   // settle time after the final drain; the worst encode gives four bytes
   localparam int         SETTLE_CYCLES   = 12;
   // generous guard, far beyond the slowest legal run
   localparam int         WATCHDOG_CYCLES = 200000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   hcbp_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   hcbp_rsp_type rsp_payload;

   // set when the previous rising edge took a request beat
   logic         req_took = 1'b0;
   int           fail_count;
   int           bytes_pending;
   int           idle_pct;
   int           stall_pct;

   // which table entries hold a code, so no unloaded byte is ever encoded
   bit                   symbol_loaded [TABLE_DEPTH];
   logic [SYM_WIDTH-1:0] loaded_symbols [$];

   huffman_code_bit_packer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   hcbp_stream_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
   end

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic hcbp_req_type make_beat(input logic [1:0] cmd,
                                              input logic [SYM_WIDTH-1:0] sym,
                                              input logic [31:0] bits,
                                              input logic [5:0] len);
      hcbp_req_type beat;
      beat.cmd       = cmd;
      beat.symbol    = sym;
      beat.code_bits = bits;
      beat.code_len  = len;
      return beat;
   endfunction

   // mostly short prefix codes and encodes of loaded bytes, with finishes,
   // overlong loads and dropped commands mixed in
   function automatic hcbp_req_type random_beat();
      hcbp_req_type beat;
      int           pick;
      int           len_pick;
      beat.cmd       = CMD_FINISH;
      beat.symbol    = SYM_WIDTH'($urandom_range(0, 255));
      beat.code_bits = $urandom();
      beat.code_len  = LEN_WIDTH'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 22 || loaded_symbols.size() == 0) begin
         beat.cmd = CMD_LOAD;
         len_pick = $urandom_range(0, 99);
         if (len_pick < 70) begin
            beat.code_len = LEN_WIDTH'($urandom_range(1, 12));
         end else if (len_pick < 86) begin
            beat.code_len = LEN_WIDTH'($urandom_range(13, LEN_LIMIT));
         end else if (len_pick < 92) begin
            beat.code_len = '0;
         end
         // otherwise the full random length stays, often too long to load
      end else if (pick < 82) begin
         beat.cmd    = CMD_ENCODE;
         beat.symbol = loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)];
      end else if (pick >= 96) begin
         beat.cmd = CMD_UNUSED;
      end
      return beat;
   endfunction

   // one request beat: optional idle gap, then hold valid until taken
   task automatic send_beat(input hcbp_req_type beat);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      if (beat.cmd == CMD_LOAD && beat.code_len <= LEN_LIMIT &&
          !symbol_loaded[beat.symbol]) begin
         symbol_loaded[beat.symbol] = 1'b1;
         loaded_symbols.push_back(beat.symbol);
      end
      req_payload = beat;
      req_valid   = 1'b1;
      do @(negedge clock); while (!req_took);
   endtask

   // stop sending until every predicted byte has been read
   task automatic drain();
      req_valid = 1'b0;
      while (bytes_pending != 0) @(negedge clock);
   endtask

   initial begin
      hcbp_req_type beat;
      int           issued;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: finish on an empty byte gives 0x00, code 3 is dropped
      send_beat(make_beat(CMD_FINISH, 8'h00, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
      // zero length, full 32 bit code, and junk above a one bit code
      send_beat(make_beat(CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0));
      send_beat(make_beat(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32));
      send_beat(make_beat(CMD_LOAD, 8'hA5, 32'hFFFF_FFFE, 6'd1));
      // overlong loads must not touch the table
      send_beat(make_beat(CMD_LOAD, 8'hFF, 32'h0000_0000, 6'd33));
      send_beat(make_beat(CMD_LOAD, 8'h3C, 32'h0000_0000, 6'd63));
      send_beat(make_beat(CMD_LOAD, 8'h3C, 32'hABCD_EF55, 6'd7));
      send_beat(make_beat(CMD_LOAD, 8'hC3, 32'h8765_4321, 6'd31));
      send_beat(make_beat(CMD_LOAD, 8'h5A, 32'h0000_0096, 6'd8));
      // no bits, then four full bytes, then the same with one bit pending
      send_beat(make_beat(CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_ENCODE, 8'hA5, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_ENCODE, 8'h3C, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_ENCODE, 8'h3C, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_ENCODE, 8'hC3, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_FINISH, 8'h00, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_FINISH, 8'h00, 32'h0000_0000, 6'd0));
      // exactly one byte, then a partial byte flushed with padding
      send_beat(make_beat(CMD_ENCODE, 8'h5A, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_ENCODE, 8'hA5, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_FINISH, 8'h00, 32'h0000_0000, 6'd0));
      // reload an entry and use the new code
      send_beat(make_beat(CMD_LOAD, 8'hFF, 32'h0000_0001, 6'd32));
      send_beat(make_beat(CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0));
      send_beat(make_beat(CMD_FINISH, 8'h00, 32'h0000_0000, 6'd0));

      // random traffic in phases: no idling, sender gaps, receiver stalls, both
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 61;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 61;
            end
            default: begin
               idle_pct  = 28;
               stall_pct = 28;
            end
         endcase
         issued = 0;
         while (issued < RANDOM_ITEMS / PHASE_COUNT) begin
            beat = random_beat();
            send_beat(beat);
            if (beat.cmd != CMD_UNUSED) begin
               issued++;
               // halfway through each phase let the output run dry
               if (issued == RANDOM_ITEMS / (2 * PHASE_COUNT)) drain();
            end
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && bytes_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hang guard
   initial begin
      repeat (WATCHDOG_CYCLES) @(posedge clock);
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_table.sv
rtl/core/hcbp_packer.sv
rtl/core/huffman_code_bit_packer_top.sv
sim/hcbp_stream_checker.sv
sim/tb_huffman_code_bit_packer_top.sv
